/* design/bsfd_pkg.sv */
`timescale 1ns / 1ps

package bsfd_pkg;

    // Link framing
    localparam logic [7:0] HEADER_BYTE = 8'h48;

    // Special words and directions
    localparam logic signed [15:0] NO_BALL_WORD = 16'sd6000;
    localparam logic signed [15:0] NO_BALL_DIR  = 16'sd5000;

    // Lower bound of each distance class in the raw word
    localparam logic signed [15:0] CLASS1_BASE = 16'sd1000;
    localparam logic signed [15:0] CLASS2_BASE = 16'sd2000;
    localparam logic signed [15:0] CLASS3_BASE = 16'sd3000;
    localparam logic signed [15:0] CLASS4_BASE = 16'sd4000;
    localparam logic signed [15:0] CLASS5_BASE = 16'sd5000;

    // Distance class codes
    localparam logic [2:0] DIST_NONE = 3'd0;
    localparam logic [2:0] DIST_1    = 3'd1;
    localparam logic [2:0] DIST_2    = 3'd2;
    localparam logic [2:0] DIST_3    = 3'd3;
    localparam logic [2:0] DIST_4    = 3'd4;
    localparam logic [2:0] DIST_5    = 3'd5;

    // Direction folding into the signed half turn
    localparam logic signed [15:0] DIR_FOLD_LIMIT = 16'sd180;
    localparam logic signed [15:0] DIR_FULL_TURN  = 16'sd360;

    // Configuration register indexes
    localparam logic [2:0] CFG_DIR_FACTOR   = 3'd0;
    localparam logic [2:0] CFG_OFFSET_DIST1 = 3'd1;
    localparam logic [2:0] CFG_OFFSET_DIST2 = 3'd2;
    localparam logic [2:0] CFG_OFFSET_DIST3 = 3'd3;
    localparam logic [2:0] CFG_OFFSET_DIST4 = 3'd4;
    localparam logic [2:0] CFG_OFFSET_DIST5 = 3'd5;

    localparam logic signed [7:0] DIR_FACTOR_RESET = 8'sd1;

    // Position within a frame
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LOW    = 2'd1,
        PH_HIGH   = 2'd2
    } t_phase;

    // One byte after framing: whether it closed a frame, and the word
    typedef struct packed {
        logic        done;
        logic [15:0] word;
    } t_frame;

    // Work carried down the arithmetic pipe
    typedef struct packed {
        logic               done;
        logic [15:0]        word;
        logic [2:0]         dist_cls;
        logic signed [15:0] dir;
    } t_stage;

endpackage

/* design/bsfd_frame_rx.sv */
`timescale 1ns / 1ps

module bsfd_frame_rx (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rx_valid,
    input  logic [7:0]      i_rx_byte,
    output logic            o_rx_ready,
    input  logic            i_next_ready,
    output logic            o_frame_valid,
    output bsfd_pkg::t_frame o_frame
);
    import bsfd_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_low;
    logic [7:0]  n_low;
    logic        r_valid;
    t_frame      r_frame;
    t_frame      n_frame;
    logic        rx_accept;

    // Load whenever the holding stage is empty or draining
    assign o_rx_ready    = !r_valid || i_next_ready;
    assign rx_accept     = i_rx_valid && o_rx_ready;
    assign o_frame_valid = r_valid;
    assign o_frame       = r_frame;

    // Track the frame position and assemble the word
    always_comb begin
        n_phase       = r_phase;
        n_low         = r_low;
        n_frame.done  = 1'b0;
        n_frame.word  = {i_rx_byte, r_low};
        unique case (r_phase)
            PH_LOW: begin
                n_low   = i_rx_byte;
                n_phase = PH_HIGH;
            end
            PH_HIGH: begin
                n_frame.done = 1'b1;
                n_phase      = PH_HEADER;
            end
            default: begin
                n_phase = (i_rx_byte == HEADER_BYTE) ? PH_LOW : PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_low   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (rx_accept) begin
                r_phase <= n_phase;
                r_low   <= n_low;
                r_valid <= 1'b1;
            end else if (i_next_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload of the holding stage
    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_frame <= n_frame;
        end
    end

endmodule

/* design/ball_sensor_frame_decoder.sv */
`timescale 1ns / 1ps

// Channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+--------------------------------------
// rx       | in        | i_rx_valid / o_rx_ready   | i_rx_byte
// res      | out       | o_res_valid / i_res_ready | o_frame_done, o_raw_word, o_distance,
//          |           |                           | o_direction, o_adjusted_direction
// cfg      | in        | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle unless a stalled result holds the pipe back.
// A byte passes the framing stage, then the decode, fold, multiply and widen stages.
// Reset is synchronous, active low; it returns to waiting for the header byte,
// clears the held word, distance and directions and restores the default factor.
// A stalled result holds the pipe stage by stage; input stays ready while any
// stage is free.

module ball_sensor_frame_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_frame_done,
    output logic signed [15:0] o_raw_word,
    output logic [2:0]         o_distance,
    output logic signed [15:0] o_direction,
    output logic signed [15:0] o_adjusted_direction,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);
    import bsfd_pkg::*;

    // Configuration
    logic signed [7:0]  r_dir_factor;
    logic [7:0]         r_offset [5];

    // Framing stage
    logic               s1_valid;
    t_frame             s1;
    logic               s2_ready;

    // Arithmetic pipe
    logic               r_v2, r_v3, r_v4;
    t_stage             r_s2, r_s3, r_s4;
    t_stage             n_s2, n_s3, n_s4;
    logic               s3_ready, s4_ready, out_ready;

    // Decode feedback for words that keep the previous pair
    logic [2:0]         r_fb_dist;
    logic signed [15:0] r_fb_dir;

    // Committed held values
    logic [15:0]        r_word_hold;
    logic [2:0]         r_dist_hold;
    logic signed [15:0] r_dir_hold;
    logic signed [15:0] r_adj_hold;

    // Result register
    logic               r_out_valid;
    logic               r_out_done;
    logic [15:0]        r_out_word;
    logic [2:0]         r_out_dist;
    logic signed [15:0] r_out_dir;
    logic signed [15:0] r_out_adj;

    logic signed [15:0] w;
    logic signed [23:0] product;
    logic [7:0]         offset;
    logic signed [15:0] offset_ext;
    logic signed [15:0] n_adj;

    // Framing
    bsfd_frame_rx u_frame_rx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .i_rx_byte     (i_rx_byte),
        .o_rx_ready    (o_rx_ready),
        .i_next_ready  (s2_ready),
        .o_frame_valid (s1_valid),
        .o_frame       (s1)
    );

    // Stage advance: a stage may load when empty or when it moves on
    assign out_ready = !r_out_valid || i_res_ready;
    assign s4_ready  = !r_v4 || out_ready;
    assign s3_ready  = !r_v3 || s4_ready;
    assign s2_ready  = !r_v2 || s3_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_factor <= DIR_FACTOR_RESET;
            for (int k = 0; k < 5; k++) begin
                r_offset[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DIR_FACTOR:   r_dir_factor <= signed'(i_cfg_data);
                CFG_OFFSET_DIST1: r_offset[0]  <= i_cfg_data;
                CFG_OFFSET_DIST2: r_offset[1]  <= i_cfg_data;
                CFG_OFFSET_DIST3: r_offset[2]  <= i_cfg_data;
                CFG_OFFSET_DIST4: r_offset[3]  <= i_cfg_data;
                CFG_OFFSET_DIST5: r_offset[4]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decode the word into distance class and raw direction
    always_comb begin
        w         = signed'(s1.word);
        n_s2.done = s1.done;
        n_s2.word = s1.word;
        priority if (w == NO_BALL_WORD) begin
            n_s2.dist_cls = DIST_NONE;
            n_s2.dir      = NO_BALL_DIR;
        end else if (w >= CLASS5_BASE) begin
            n_s2.dist_cls = DIST_5;
            n_s2.dir      = w - CLASS5_BASE;
        end else if (w >= CLASS4_BASE) begin
            n_s2.dist_cls = DIST_4;
            n_s2.dir      = w - CLASS4_BASE;
        end else if (w >= CLASS3_BASE) begin
            n_s2.dist_cls = DIST_3;
            n_s2.dir      = w - CLASS3_BASE;
        end else if (w >= CLASS2_BASE) begin
            n_s2.dist_cls = DIST_2;
            n_s2.dir      = w - CLASS2_BASE;
        end else if (w >= CLASS1_BASE) begin
            n_s2.dist_cls = DIST_1;
            n_s2.dir      = w - CLASS1_BASE;
        end else begin
            n_s2.dist_cls = r_fb_dist;
            n_s2.dir      = r_fb_dir;
        end
    end

    // Fold directions past the half turn
    always_comb begin
        n_s3 = r_s2;
        if (r_s2.dir > DIR_FOLD_LIMIT && r_s2.dir != NO_BALL_DIR) begin
            n_s3.dir = r_s2.dir - DIR_FULL_TURN;
        end
    end

    // Scale by the direction factor, wrapping to 16 bits
    always_comb begin
        product  = 24'(r_s3.dir) * 24'(r_dir_factor);
        n_s4     = r_s3;
        n_s4.dir = product[15:0];
    end

    // Widen away from zero by the class offset; hold when no ball
    always_comb begin
        unique case (r_s4.dist_cls)
            DIST_1:  offset = r_offset[0];
            DIST_2:  offset = r_offset[1];
            DIST_3:  offset = r_offset[2];
            DIST_4:  offset = r_offset[3];
            DIST_5:  offset = r_offset[4];
            default: offset = '0;
        endcase
        offset_ext = signed'({8'b0, offset});
        priority if (r_s4.dir == NO_BALL_DIR) begin
            n_adj = r_adj_hold;
        end else if (r_s4.dir < 0) begin
            n_adj = r_s4.dir - offset_ext;
        end else if (r_s4.dir > 0) begin
            n_adj = r_s4.dir + offset_ext;
        end else begin
            n_adj = r_s4.dir;
        end
    end

    // Pipe valid bits and decode feedback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            r_fb_dist   <= '0;
            r_fb_dir    <= '0;
        end else begin
            if (s2_ready) r_v2 <= s1_valid;
            if (s3_ready) r_v3 <= r_v2;
            if (s4_ready) r_v4 <= r_v3;
            if (out_ready) r_out_valid <= r_v4;
            if (s2_ready && s1_valid && s1.done) begin
                r_fb_dist <= n_s2.dist_cls;
            end
            if (s4_ready && r_v3 && r_s3.done) begin
                r_fb_dir <= n_s4.dir;
            end
        end
    end

    // Pipe payload
    always_ff @(posedge i_clk) begin
        if (s2_ready && s1_valid) r_s2 <= n_s2;
        if (s3_ready && r_v2)     r_s3 <= n_s3;
        if (s4_ready && r_v3)     r_s4 <= n_s4;
    end

    // Commit held values as frame results leave the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_hold <= '0;
            r_dist_hold <= '0;
            r_dir_hold  <= '0;
            r_adj_hold  <= '0;
        end else if (out_ready && r_v4 && r_s4.done) begin
            r_word_hold <= r_s4.word;
            r_dist_hold <= r_s4.dist_cls;
            r_dir_hold  <= r_s4.dir;
            r_adj_hold  <= n_adj;
        end
    end

    // Result register: fresh values for a frame, held values otherwise
    always_ff @(posedge i_clk) begin
        if (out_ready && r_v4) begin
            r_out_done <= r_s4.done;
            if (r_s4.done) begin
                r_out_word <= r_s4.word;
                r_out_dist <= r_s4.dist_cls;
                r_out_dir  <= r_s4.dir;
                r_out_adj  <= n_adj;
            end else begin
                r_out_word <= r_word_hold;
                r_out_dist <= r_dist_hold;
                r_out_dir  <= r_dir_hold;
                r_out_adj  <= r_adj_hold;
            end
        end
    end

    assign o_res_valid          = r_out_valid;
    assign o_frame_done         = r_out_done;
    assign o_raw_word           = signed'(r_out_word);
    assign o_distance           = r_out_dist;
    assign o_direction          = r_out_dir;
    assign o_adjusted_direction = r_out_adj;

    // Frames are at least three bytes apart, so feedback is settled before use
    a_frame_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_s4.done) |-> !(r_v3 && r_s3.done) && !(r_v2 && r_s2.done))
        else $error("two frame completions closer than three bytes in the pipe");

    // Distance class stays within range
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_distance <= DIST_5))
        else $error("distance class out of range");

    // The no-ball word always clears the distance
    a_no_ball: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_done && o_raw_word == NO_BALL_WORD)
            |-> (o_distance == DIST_NONE))
        else $error("no-ball word with non-zero distance");

    // A delivered frame result matches what is held afterwards
    a_hold_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_frame_done)
            |=> (r_adj_hold == $past(o_adjusted_direction)) &&
                (r_dir_hold == $past(o_direction)))
        else $error("held directions differ from the last frame result");

endmodule
